// ===== hdl/psl_pkg.sv =====
package psl_pkg;

	// Stream payload widths
	localparam int NUMBER_W = 18;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 8;

	// Sieve builder phases
	typedef enum logic [2:0] {
		S_CLEAR,
		S_BASE_RD,
		S_BASE_CHK,
		S_MARK,
		S_DONE
	} sieve_state_t;

endpackage

// ===== hdl/psl_map_ram.sv =====
module psl_map_ram #(
	parameter int DEPTH  = 2048,
	parameter int WIDTH  = 64,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds data when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/psl_sieve.sv =====
module psl_sieve #(
	parameter int LIMIT  = 262144,
	parameter int BIT_W  = 6,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic                    clk,
	input  logic                    arst_n,
	output logic                    done,
	output logic                    rd_en,
	output logic [ADDR_W-1:0]       rd_addr,
	input  logic [(1<<BIT_W)-1:0]   rd_data,
	output logic                    wr_en,
	output logic [ADDR_W-1:0]       wr_addr,
	output logic [(1<<BIT_W)-1:0]   wr_data
);
	import psl_pkg::*;

	localparam int WB    = 1 << BIT_W;
	localparam int CNT_W = $clog2(LIMIT) + 1;

	sieve_state_t state_q, state_d;

	logic [ADDR_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0]  b_q, b_d;
	logic [CNT_W-1:0]  sq_q, sq_d;
	logic [CNT_W-1:0]  step_q, step_d;
	logic [CNT_W-1:0]  m_q, m_d;

	logic              mark_c;
	logic [BIT_W-1:0]  rd_bit_c;
	logic              mark_v_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [BIT_W-1:0]  rd_bit_s1;

	logic              wl_v_q;
	logic [ADDR_W-1:0] wl_addr_q;
	logic [WB-1:0]     wl_data_q;
	logic [WB-1:0]     rd_eff;

	// Word address of an odd value: bit (v >> 1) % WB of word (v >> 1) / WB
	function automatic logic [ADDR_W-1:0] word_of(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] w;
		w = v >> (BIT_W + 1);
		return w[ADDR_W-1:0];
	endfunction

	// Forward the last write over a stale read of the same word
	assign rd_eff = (wl_v_q && wl_addr_q == rd_addr_s1) ? wl_data_q : rd_data;

	assign done = (state_q == S_DONE);

	// Sequencer: clear sweep, base test, multiple marking
	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		b_d      = b_q;
		sq_d     = sq_q;
		step_d   = step_q;
		m_d      = m_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		rd_bit_c = '0;
		mark_c   = 1'b0;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = S_BASE_RD;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_BASE_RD: begin
				if (sq_q >= CNT_W'(LIMIT)) begin
					state_d = S_DONE;
				end else begin
					rd_en    = 1'b1;
					rd_addr  = word_of(b_q);
					rd_bit_c = b_q[BIT_W:1];
					state_d  = S_BASE_CHK;
				end
			end
			S_BASE_CHK: begin
				if (rd_eff[rd_bit_s1]) begin
					b_d     = b_q + CNT_W'(2);
					sq_d    = sq_q + (step_q << 1) + CNT_W'(4);
					step_d  = step_q + CNT_W'(4);
					state_d = S_BASE_RD;
				end else begin
					m_d     = sq_q;
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				if (m_q < CNT_W'(LIMIT)) begin
					rd_en    = 1'b1;
					rd_addr  = word_of(m_q);
					rd_bit_c = m_q[BIT_W:1];
					mark_c   = 1'b1;
					m_d      = m_q + step_q;
				end else begin
					b_d     = b_q + CNT_W'(2);
					sq_d    = sq_q + (step_q << 1) + CNT_W'(4);
					step_d  = step_q + CNT_W'(4);
					state_d = S_BASE_RD;
				end
			end
			S_DONE: begin
			end
			default: begin
				state_d = S_DONE;
			end
		endcase
	end

	// Write port: mark modify-write, else clear sweep
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (mark_v_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_addr_s1;
			wr_data = rd_eff | (WB'(1) << rd_bit_s1);
		end else if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			b_q       <= CNT_W'(3);
			sq_q      <= CNT_W'(9);
			step_q    <= CNT_W'(6);
			m_q       <= '0;
			mark_v_s1 <= 1'b0;
			wl_v_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			b_q       <= b_d;
			sq_q      <= sq_d;
			step_q    <= step_d;
			m_q       <= m_d;
			mark_v_s1 <= mark_c;
			if (wr_en) begin
				wl_v_q <= 1'b1;
			end
		end
	end

	// Read-side and last-write payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_s1 <= rd_addr;
			rd_bit_s1  <= rd_bit_c;
		end
		if (wr_en) begin
			wl_addr_q <= wr_addr;
			wl_data_q <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> done)
		else $error("sieve left done");

	a_no_mark_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !mark_v_s1)
		else $error("mark write during clear sweep");

	a_mark_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mark_v_s1 |-> (rd_addr_s1 <= ADDR_W'(DEPTH - 1)))
		else $error("mark write beyond map");
`endif

endmodule

// ===== hdl/prime_sieve_lookup.sv =====
// Primality lookup over a sieve bitmap of odd numbers held in one RAM.
// After reset the map is cleared, one word per cycle, then sieved: each odd base is
// read and tested and, if unmarked, its odd multiples from its square are marked.
// s_tready stays low until the sieve finishes; then one number per cycle while the
// output does not stall. Each result passes the RAM read and the output register.
// Reset: arst_n asynchronous, active low; restarts the clear and sieve.
module prime_sieve_lookup #(
	parameter int LIMIT     = 262144,
	parameter int WORD_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [psl_pkg::S_DATA_W-1:0]   s_tdata,  // [17:0] number
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [psl_pkg::M_DATA_W-1:0]   m_tdata   // [0] prime flag
);
	import psl_pkg::*;

	localparam int BIT_W  = $clog2(WORD_BITS + 1) - 1;
	localparam int WB     = 1 << BIT_W;
	localparam int HALF   = (LIMIT + 1) / 2;
	localparam int DEPTH  = (HALF + WB - 1) / WB;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(LIMIT) + 1;
	localparam int QW     = (CNT_W > NUMBER_W) ? CNT_W : NUMBER_W;

	logic              sieve_done;
	logic              sv_rd_en;
	logic [ADDR_W-1:0] sv_rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WB-1:0]     wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [WB-1:0]     rd_data;

	logic [QW-1:0]     num_x;
	logic [QW-1:0]     num_w;
	logic              acc;
	logic              adv;
	logic              pre_c;
	logic              use_map_c;

	logic              v_s1;
	logic              pre_s1;
	logic              use_map_s1;
	logic [BIT_W-1:0]  bit_s1;
	logic              out_v_q;
	logic              prime_q;

	psl_map_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (WB),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	psl_sieve #(
		.LIMIT  (LIMIT),
		.BIT_W  (BIT_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.done    (sieve_done),
		.rd_en   (sv_rd_en),
		.rd_addr (sv_rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Handshake: s1 moves on when the output register is free or drained
	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = sieve_done && (!v_s1 || adv);
	assign acc      = s_tvalid && s_tready;

	// Query decode
	assign num_x = QW'(s_tdata[NUMBER_W-1:0]);
	assign num_w = num_x >> (BIT_W + 1);
	always_comb begin
		pre_c     = 1'b0;
		use_map_c = 1'b0;
		if (num_x == QW'(2)) begin
			pre_c = 1'b1;
		end else if (!num_x[0] || num_x == QW'(1)) begin
			pre_c = 1'b0;
		end else if (num_x >= QW'(LIMIT)) begin
			pre_c = 1'b0;
		end else begin
			use_map_c = 1'b1;
		end
	end

	// RAM read port: sieve owns it until done
	assign rd_en   = sieve_done ? acc : sv_rd_en;
	assign rd_addr = sieve_done ? num_w[ADDR_W-1:0] : sv_rd_addr;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			pre_s1     <= pre_c;
			use_map_s1 <= use_map_c;
			bit_s1     <= num_x[BIT_W:1];
		end
		if (adv) begin
			prime_q <= use_map_s1 ? !rd_data[bit_s1] : pre_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_DATA_W - 1){1'b0}}, prime_q};

`ifndef SYNTHESIS
	a_query_after_sieve: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> sieve_done)
		else $error("query in flight before sieve done");

	a_ram_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sieve_done |-> !wr_en)
		else $error("map written after sieve done");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
`endif

endmodule
